// ----- rtl/clts_pkg.sv -----
package clts_pkg;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    CMD_QUERY    = 3'd0,
    CMD_APPEND   = 3'd1,
    CMD_COMPACT  = 3'd2,
    CMD_CREATE   = 3'd3,
    CMD_APPLY    = 3'd4,
    CMD_BOUNDS   = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_OK          = 3'd0,
    STAT_COMPACTED   = 3'd1,
    STAT_UNAVAILABLE = 3'd2,
    STAT_OUT_OF_BOUND = 3'd3,
    STAT_OLD_SNAP    = 3'd4,
    STAT_FULL        = 3'd5
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // index relations computed at accept time
  typedef struct packed {
    logic          below;
    logic          at_base;
    logic          in_range;
    logic          next_slot;
    logic          le_snap;
    logic [CW-1:0] off;
  } flags_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] term_out;
    logic [63:0] first_avail;
    logic [63:0] last_stored;
  } result_t;

  function automatic logic [AW-1:0] slot_of(input logic [63:0] idx);
    slot_of = AW'(idx % 64'(DEPTH));
  endfunction

endpackage

// ----- rtl/consensus_log_term_store_top.sv -----
// Term store of a consensus log: every request (query, append, compact, create
// snapshot, apply snapshot, bounds) returns exactly one result with a status and
// the first and last index as they stand after the request. Terms live in a ring
// of DEPTH slots in one synchronous RAM. A request is handled in two steps: the
// accept step reads the ring slot and registers the index compares against the
// base and the snapshot mark, the execute step decides, writes the slot back and
// loads the result register. One request is in flight at a time; a new request
// is taken while the previous result waits in the output register, and the
// execute step stalls only while that register is still held.
module consensus_log_term_store_top import clts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [63:0] log_index,
  input  logic [63:0] entry_term,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [63:0] term_out,
  output logic [63:0] first_avail,
  output logic [63:0] last_stored
);

  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [63:0]   mem_rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [63:0]   mem_wdata;
  logic          res_ready;
  logic          res_valid;
  result_t       res;
  result_t       out_q;

  clts_ram #(
    .WIDTH(64),
    .DEPTH(DEPTH)
  ) u_ring (
    .clk   (clk),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata)
  );

  clts_core u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .log_index  (log_index),
    .entry_term (entry_term),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .res        (res)
  );

  // output register frees up in the same cycle it is taken
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign status      = out_q.status;
  assign term_out    = out_q.term_out;
  assign first_avail = out_q.first_avail;
  assign last_stored = out_q.last_stored;

endmodule

// ----- rtl/clts_ram.sv -----
module clts_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/clts_core.sv -----
module clts_core import clts_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    cmd,
  input  logic [63:0]   log_index,
  input  logic [63:0]   entry_term,
  output logic          mem_re,
  output logic [AW-1:0] mem_raddr,
  input  logic [63:0]   mem_rdata,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [63:0]   mem_wdata,
  input  logic          res_ready,
  output logic          res_valid,
  output result_t       res
);

  state_t        state, state_next;
  logic [2:0]    cmd_q;
  logic [63:0]   idx_q;
  logic [63:0]   term_q;
  flags_t        flags_q, flags_next;

  logic [63:0]   base_index, base_index_next;
  logic [63:0]   base_term, base_term_next;
  logic [CW-1:0] entry_count, entry_count_next;
  logic [63:0]   snap_mark, snap_mark_next;
  logic [63:0]   snap_term, snap_term_next;

  logic          accept;
  logic          exec_go;
  logic [63:0]   off_full;
  status_t       status_c;
  logic [63:0]   term_c;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_EXEC;
      ST_EXEC: if (res_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready = 1'b0;
    exec_go  = 1'b0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_EXEC: exec_go  = res_ready;
      default: ;
    endcase
  end

  assign accept    = in_valid && in_ready;
  assign mem_re    = accept;
  assign mem_raddr = slot_of(log_index);

  // offset relations against the current base and snapshot mark, registered with the request
  always_comb begin
    off_full             = log_index - base_index;
    flags_next.below     = log_index < base_index;
    flags_next.at_base   = log_index == base_index;
    flags_next.in_range  = off_full <= 64'(entry_count);
    flags_next.next_slot = off_full == (64'(entry_count) + 64'd1);
    flags_next.le_snap   = log_index <= snap_mark;
    flags_next.off       = off_full[CW-1:0];
  end

  always_comb begin
    base_index_next  = base_index;
    base_term_next   = base_term;
    entry_count_next = entry_count;
    snap_mark_next   = snap_mark;
    snap_term_next   = snap_term;
    status_c         = STAT_OK;
    term_c           = '0;
    mem_we           = 1'b0;
    case (cmd_t'(cmd_q))
      CMD_QUERY: begin
        if (flags_q.below) begin
          status_c = STAT_COMPACTED;
        end else if (!flags_q.in_range) begin
          status_c = STAT_UNAVAILABLE;
        end else if (flags_q.at_base) begin
          term_c = base_term;
        end else begin
          term_c = mem_rdata;
        end
      end
      CMD_APPEND: begin
        if (!flags_q.below && !flags_q.at_base) begin
          if (flags_q.in_range) begin
            mem_we           = 1'b1;
            entry_count_next = flags_q.off;
          end else if (flags_q.next_slot) begin
            if (entry_count == CW'(DEPTH)) begin
              status_c = STAT_FULL;
            end else begin
              mem_we           = 1'b1;
              entry_count_next = flags_q.off;
            end
          end else begin
            status_c = STAT_OUT_OF_BOUND;
          end
        end
      end
      CMD_COMPACT: begin
        if (flags_q.below || flags_q.at_base) begin
          status_c = STAT_COMPACTED;
        end else if (!flags_q.in_range) begin
          status_c = STAT_OUT_OF_BOUND;
        end else begin
          base_term_next   = mem_rdata;
          base_index_next  = idx_q;
          entry_count_next = entry_count - flags_q.off;
        end
      end
      CMD_CREATE: begin
        if (flags_q.le_snap) begin
          status_c = STAT_OLD_SNAP;
        end else if (flags_q.below) begin
          status_c = STAT_COMPACTED;
        end else if (!flags_q.in_range) begin
          status_c = STAT_OUT_OF_BOUND;
        end else begin
          term_c         = flags_q.at_base ? base_term : mem_rdata;
          snap_mark_next = idx_q;
          snap_term_next = term_c;
        end
      end
      CMD_APPLY: begin
        if (flags_q.le_snap) begin
          status_c = STAT_OLD_SNAP;
        end else begin
          snap_mark_next   = idx_q;
          snap_term_next   = term_q;
          base_index_next  = idx_q;
          base_term_next   = term_q;
          entry_count_next = '0;
        end
      end
      default: ;
    endcase
    mem_we = mem_we && exec_go;
  end

  assign mem_waddr = slot_of(idx_q);
  assign mem_wdata = term_q;

  assign res_valid       = exec_go;
  assign res.status      = status_c;
  assign res.term_out    = term_c;
  assign res.first_avail = base_index_next + 64'd1;
  assign res.last_stored = base_index_next + 64'(entry_count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      base_index  <= '0;
      base_term   <= '0;
      entry_count <= '0;
      snap_mark   <= '0;
      snap_term   <= '0;
    end else begin
      state <= state_next;
      if (exec_go) begin
        base_index  <= base_index_next;
        base_term   <= base_term_next;
        entry_count <= entry_count_next;
        snap_mark   <= snap_mark_next;
        snap_term   <= snap_term_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= cmd;
      idx_q   <= log_index;
      term_q  <= entry_term;
      flags_q <= flags_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(DEPTH))
    else $error("entry count above ring depth");

  a_exec_after_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(state == ST_EXEC) |-> $past(in_valid && in_ready))
    else $error("execute entered without a request");

  a_write_in_exec: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_EXEC && res_ready))
    else $error("ring written outside execute");

  a_apply_resets: assert property (@(posedge clk) disable iff (rst)
    (exec_go && cmd_t'(cmd_q) == CMD_APPLY && !flags_q.le_snap)
      |=> (entry_count == '0 && base_index == snap_mark))
    else $error("apply snapshot left stale bounds");

endmodule
